[sv/bdiou_pkg.sv]
// ----------------------------------------------------------------------------
// bdiou_pkg
// shared types for the box distance iou unit
// ----------------------------------------------------------------------------
package bdiou_pkg;

    localparam int OVL_BITS  = 16;
    localparam int DIST_BITS = 17;

    typedef struct packed {
        logic valid;
        logic degenerate;
    } ctl_t;

endpackage

[sv/box_distance_iou_unit.sv]
// ----------------------------------------------------------------------------
// box_distance_iou_unit
// iou and distance iou of two boxes, fully pipelined
// ----------------------------------------------------------------------------
// One box pair is taken every clock cycle; busy is always low. The result
// appears with done high after it has passed two geometry stages, then a
// chain of FRAC_BITS + 1 division cells that each retire one quotient bit
// of both ratios, then one output register. The receiver cannot stall and
// must take each word in its done cycle.
module box_distance_iou_unit
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 15
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [COORD_BITS-1:0]                box_a_x,
    input  logic [COORD_BITS-1:0]                box_a_y,
    input  logic [COORD_BITS-1:0]                box_a_w,
    input  logic [COORD_BITS-1:0]                box_a_h,
    input  logic [COORD_BITS-1:0]                box_b_x,
    input  logic [COORD_BITS-1:0]                box_b_y,
    input  logic [COORD_BITS-1:0]                box_b_w,
    input  logic [COORD_BITS-1:0]                box_b_h,
    output logic                                 done,
    output logic [bdiou_pkg::OVL_BITS-1:0]       overlap_ratio,
    output logic signed [bdiou_pkg::DIST_BITS-1:0] distance_ratio,
    output logic                                 degenerate
);
    import bdiou_pkg::*;

    localparam int DEN  = 2 * COORD_BITS + 5;
    localparam int QB   = FRAC_BITS + 1;
    localparam int NUM  = QB;
    localparam int NC   = QB;

    ctl_t                  g_ctl, c0;
    logic [2*COORD_BITS+1:0] g_inter, g_uni;
    logic [2*COORD_BITS+4:0] g_dist2, g_diag4;

    ctl_t                  ctl_c   [NC+1];
    logic [NUM-1:0]        num_a_c [NC+1];
    logic [NUM-1:0]        num_b_c [NC+1];
    logic [DEN:0]          rem_a_c [NC+1];
    logic [DEN:0]          rem_b_c [NC+1];
    logic [DEN-1:0]        den_a_c [NC+1];
    logic [DEN-1:0]        den_b_c [NC+1];

    logic                  done_reg, deg_reg;
    logic [OVL_BITS-1:0]   ovl_reg;
    logic [DIST_BITS-1:0]  dist_reg;
    logic [QB-1:0]         qa, qb;
    logic [DIST_BITS:0]    diff;

    bdiou_geom #(.COORD_BITS(COORD_BITS)) u_geom
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .box_a_x (box_a_x),
        .box_a_y (box_a_y),
        .box_a_w (box_a_w),
        .box_a_h (box_a_h),
        .box_b_x (box_b_x),
        .box_b_y (box_b_y),
        .box_b_w (box_b_w),
        .box_b_h (box_b_h),
        .ctl     (g_ctl),
        .inter   (g_inter),
        .uni     (g_uni),
        .dist2   (g_dist2),
        .diag4   (g_diag4)
    );

    always_comb
    begin
        c0.valid      = g_ctl.valid;
        c0.degenerate = (g_uni == '0) || (g_diag4 == '0);
    end

    // degenerate pairs divide 0 by 1 so both quotients come out zero
    // remainder starts at half the numerator, its low bit is shifted in first
    assign ctl_c[0]   = c0;
    assign num_a_c[0] = c0.degenerate ? '0 : {g_inter[0], {(QB-1){1'b0}}};
    assign rem_a_c[0] = c0.degenerate ? '0 : (DEN+1)'(g_inter >> 1);
    assign num_b_c[0] = c0.degenerate ? '0 : {g_dist2[0], {(QB-1){1'b0}}};
    assign rem_b_c[0] = c0.degenerate ? '0 : (DEN+1)'(g_dist2 >> 1);
    assign den_a_c[0] = c0.degenerate ? DEN'(1) : DEN'(g_uni);
    assign den_b_c[0] = c0.degenerate ? DEN'(1) : g_diag4;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        bdiou_div_cell #(.NUM_BITS(NUM), .DEN_BITS(DEN)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_c[i]),
            .num_a_in  (num_a_c[i]),
            .rem_a_in  (rem_a_c[i]),
            .den_a_in  (den_a_c[i]),
            .num_b_in  (num_b_c[i]),
            .rem_b_in  (rem_b_c[i]),
            .den_b_in  (den_b_c[i]),
            .ctl_out   (ctl_c[i+1]),
            .num_a_out (num_a_c[i+1]),
            .rem_a_out (rem_a_c[i+1]),
            .den_a_out (den_a_c[i+1]),
            .num_b_out (num_b_c[i+1]),
            .rem_b_out (rem_b_c[i+1]),
            .den_b_out (den_b_c[i+1])
        );
    end

    always_comb
    begin
        qa   = num_a_c[NC][QB-1:0];
        qb   = num_b_c[NC][QB-1:0];
        diff = (DIST_BITS+1)'(qa) - (DIST_BITS+1)'(qb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_c[NC].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ovl_reg  <= OVL_BITS'(qa);
        dist_reg <= diff[DIST_BITS-1:0];
        deg_reg  <= ctl_c[NC].degenerate;
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign overlap_ratio  = ovl_reg;
    assign distance_ratio = dist_reg;
    assign degenerate     = deg_reg;

endmodule

[sv/bdiou_div_cell.sv]
// ----------------------------------------------------------------------------
// bdiou_div_cell
// one restoring division step for the iou and penalty quotients
// ----------------------------------------------------------------------------
module bdiou_div_cell
#(
    parameter int NUM_BITS = 56,
    parameter int DEN_BITS = 28
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdiou_pkg::ctl_t     ctl_in,
    input  logic [NUM_BITS-1:0] num_a_in,
    input  logic [DEN_BITS:0]   rem_a_in,
    input  logic [DEN_BITS-1:0] den_a_in,
    input  logic [NUM_BITS-1:0] num_b_in,
    input  logic [DEN_BITS:0]   rem_b_in,
    input  logic [DEN_BITS-1:0] den_b_in,
    output bdiou_pkg::ctl_t     ctl_out,
    output logic [NUM_BITS-1:0] num_a_out,
    output logic [DEN_BITS:0]   rem_a_out,
    output logic [DEN_BITS-1:0] den_a_out,
    output logic [NUM_BITS-1:0] num_b_out,
    output logic [DEN_BITS:0]   rem_b_out,
    output logic [DEN_BITS-1:0] den_b_out
);
    import bdiou_pkg::*;

    ctl_t                ctl_reg;
    logic [NUM_BITS-1:0] num_a_reg, num_b_reg, num_a_next, num_b_next;
    logic [DEN_BITS:0]   rem_a_reg, rem_b_reg, rem_a_next, rem_b_next;
    logic [DEN_BITS-1:0] den_a_reg, den_b_reg;
    logic [DEN_BITS+1:0] sh_a, sh_b;

    always_comb
    begin
        sh_a = {rem_a_in, num_a_in[NUM_BITS-1]};
        sh_b = {rem_b_in, num_b_in[NUM_BITS-1]};
        num_a_next = {num_a_in[NUM_BITS-2:0], 1'b0};
        num_b_next = {num_b_in[NUM_BITS-2:0], 1'b0};
        rem_a_next = sh_a[DEN_BITS:0];
        rem_b_next = sh_b[DEN_BITS:0];
        if (sh_a >= {2'b00, den_a_in})
        begin
            rem_a_next = (DEN_BITS+1)'(sh_a - {2'b00, den_a_in});
            num_a_next[0] = 1'b1;
        end
        if (sh_b >= {2'b00, den_b_in})
        begin
            rem_b_next = (DEN_BITS+1)'(sh_b - {2'b00, den_b_in});
            num_b_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        den_a_reg <= den_a_in;
        den_b_reg <= den_b_in;
    end

    assign ctl_out   = ctl_reg;
    assign num_a_out = num_a_reg;
    assign num_b_out = num_b_reg;
    assign rem_a_out = rem_a_reg;
    assign rem_b_out = rem_b_reg;
    assign den_a_out = den_a_reg;
    assign den_b_out = den_b_reg;

endmodule

[sv/bdiou_geom.sv]
// ----------------------------------------------------------------------------
// bdiou_geom
// intersection, union, squared enclosing diagonal and center distance, two stages
// ----------------------------------------------------------------------------
module bdiou_geom
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COORD_BITS-1:0]   box_a_x,
    input  logic [COORD_BITS-1:0]   box_a_y,
    input  logic [COORD_BITS-1:0]   box_a_w,
    input  logic [COORD_BITS-1:0]   box_a_h,
    input  logic [COORD_BITS-1:0]   box_b_x,
    input  logic [COORD_BITS-1:0]   box_b_y,
    input  logic [COORD_BITS-1:0]   box_b_w,
    input  logic [COORD_BITS-1:0]   box_b_h,
    output bdiou_pkg::ctl_t         ctl,
    output logic [2*COORD_BITS+1:0] inter,
    output logic [2*COORD_BITS+1:0] uni,
    output logic [2*COORD_BITS+4:0] dist2,
    output logic [2*COORD_BITS+4:0] diag4
);
    import bdiou_pkg::*;

    localparam int E = COORD_BITS + 1;
    localparam int D = COORD_BITS + 2;
    localparam int P = 2 * COORD_BITS;

    logic [E-1:0] ar, ab, br, bb, ix0, ix1, iy0, iy1, ew, eh;
    logic [E-1:0] ow_next, oh_next;
    logic [D-1:0] ca_x, ca_y, cb_x, cb_y, dx_next, dy_next;

    logic         v1_reg;
    logic [E-1:0] ow_reg, oh_reg, ew_reg, eh_reg;
    logic [D-1:0] dx_reg, dy_reg;
    logic [P-1:0] aa_reg, ba_reg;

    logic [P+1:0] inter_w;
    logic [P+2:0] sum_area;
    logic [P+1:0] ew2, eh2;
    logic [P+3:0] dx2, dy2;

    ctl_t         ctl_reg;
    logic [P+1:0] inter_reg, uni_reg;
    logic [P+4:0] dist2_reg, diag4_reg;

    always_comb
    begin
        ar = E'(box_a_x) + E'(box_a_w);
        ab = E'(box_a_y) + E'(box_a_h);
        br = E'(box_b_x) + E'(box_b_w);
        bb = E'(box_b_y) + E'(box_b_h);
        ix0 = (box_a_x > box_b_x) ? E'(box_a_x) : E'(box_b_x);
        iy0 = (box_a_y > box_b_y) ? E'(box_a_y) : E'(box_b_y);
        ix1 = (ar < br) ? ar : br;
        iy1 = (ab < bb) ? ab : bb;
        ow_next = (ix1 > ix0) ? ix1 - ix0 : '0;
        oh_next = (iy1 > iy0) ? iy1 - iy0 : '0;
        ew = ((ar > br) ? ar : br) - ((box_a_x < box_b_x) ? E'(box_a_x) : E'(box_b_x));
        eh = ((ab > bb) ? ab : bb) - ((box_a_y < box_b_y) ? E'(box_a_y) : E'(box_b_y));
        ca_x = {box_a_x, 1'b0} + D'(box_a_w);
        cb_x = {box_b_x, 1'b0} + D'(box_b_w);
        ca_y = {box_a_y, 1'b0} + D'(box_a_h);
        cb_y = {box_b_y, 1'b0} + D'(box_b_h);
        dx_next = (ca_x > cb_x) ? ca_x - cb_x : cb_x - ca_x;
        dy_next = (ca_y > cb_y) ? ca_y - cb_y : cb_y - ca_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            v1_reg        <= start;
            ctl_reg.valid <= v1_reg;
            ctl_reg.degenerate <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
        oh_reg <= oh_next;
        ew_reg <= ew;
        eh_reg <= eh;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        aa_reg <= box_a_w * box_a_h;
        ba_reg <= box_b_w * box_b_h;
    end

    always_comb
    begin
        inter_w  = ow_reg * oh_reg;
        sum_area = (P+3)'(aa_reg) + (P+3)'(ba_reg);
        ew2 = ew_reg * ew_reg;
        eh2 = eh_reg * eh_reg;
        dx2 = dx_reg * dx_reg;
        dy2 = dy_reg * dy_reg;
    end

    always_ff @(posedge clk)
    begin
        inter_reg <= inter_w;
        uni_reg   <= (P+2)'(sum_area - (P+3)'(inter_w));
        dist2_reg <= (P+5)'(dx2) + (P+5)'(dy2);
        diag4_reg <= {(P+3)'(ew2) + (P+3)'(eh2), 2'b00};
    end

    assign ctl   = ctl_reg;
    assign inter = inter_reg;
    assign uni   = uni_reg;
    assign dist2 = dist2_reg;
    assign diag4 = diag4_reg;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// checks the box distance iou unit against an integer model of iou and
// distance iou; box pairs are sent with random gaps, every done word is
// compared with the oldest predicted word
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdiou_pkg::*;

    localparam int CB = 12;
    localparam int FB = 15;
    localparam int LATENCY = FB + 4;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [CB-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    } pair_t;

    typedef struct packed {
        logic [OVL_BITS-1:0]         ovl;
        logic signed [DIST_BITS-1:0] dratio;
        logic                        degen;
    } score_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [CB-1:0] box_a_x, box_a_y, box_a_w, box_a_h;
    logic [CB-1:0] box_b_x, box_b_y, box_b_w, box_b_h;
    logic done;
    logic [OVL_BITS-1:0] overlap_ratio;
    logic signed [DIST_BITS-1:0] distance_ratio;
    logic degenerate;

    score_t expected_scores[$];
    int errors = 0;
    int idle_cycles = 0;

    box_distance_iou_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .box_a_x(box_a_x), .box_a_y(box_a_y), .box_a_w(box_a_w), .box_a_h(box_a_h),
        .box_b_x(box_b_x), .box_b_y(box_b_y), .box_b_w(box_b_w), .box_b_h(box_b_h),
        .done(done), .overlap_ratio(overlap_ratio), .distance_ratio(distance_ratio),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint unsigned span_overlap(longint unsigned a0, longint unsigned a1,
                                                     longint unsigned b0, longint unsigned b1);
        longint unsigned s, e;
        s = (a0 > b0) ? a0 : b0;
        e = (a1 < b1) ? a1 : b1;
        return (e > s) ? e - s : 0;
    endfunction

    function automatic score_t score_pair(pair_t p);
        longint unsigned ar, ab, br, bb, inter, uni, ew, eh, diag4, ca, cb2, dx, dy, dist2;
        longint unsigned iou_q, pen_q;
        score_t s;
        ar = p.ax + p.aw;
        ab = p.ay + p.ah;
        br = p.bx + p.bw;
        bb = p.by + p.bh;
        inter = span_overlap(p.ax, ar, p.bx, br) * span_overlap(p.ay, ab, p.by, bb);
        uni = longint'(p.aw) * p.ah + longint'(p.bw) * p.bh - inter;
        ew = ((ar > br) ? ar : br) - ((p.ax < p.bx) ? p.ax : p.bx);
        eh = ((ab > bb) ? ab : bb) - ((p.ay < p.by) ? p.ay : p.by);
        diag4 = 4 * (ew * ew + eh * eh);
        ca = 2 * longint'(p.ax) + p.aw;
        cb2 = 2 * longint'(p.bx) + p.bw;
        dx = (ca > cb2) ? ca - cb2 : cb2 - ca;
        ca = 2 * longint'(p.ay) + p.ah;
        cb2 = 2 * longint'(p.by) + p.bh;
        dy = (ca > cb2) ? ca - cb2 : cb2 - ca;
        dist2 = dx * dx + dy * dy;
        if (uni == 0 || diag4 == 0)
        begin
            s.ovl = '0;
            s.dratio = '0;
            s.degen = 1'b1;
        end
        else
        begin
            iou_q = (inter << FB) / uni;
            pen_q = (dist2 << FB) / diag4;
            s.ovl = iou_q[OVL_BITS-1:0];
            s.dratio = DIST_BITS'(iou_q - pen_q);
            s.degen = 1'b0;
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker and watchdog
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n)
        begin
            idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
            if (done)
            begin
                if (expected_scores.size() == 0)
                begin
                    report_mismatch("done without pending word", done, 0);
                end
                else
                begin
                    want = expected_scores.pop_front();
                    if (overlap_ratio !== want.ovl)
                        report_mismatch("overlap_ratio", overlap_ratio, want.ovl);
                    if (distance_ratio !== want.dratio)
                        report_mismatch("distance_ratio", distance_ratio, want.dratio);
                    if (degenerate !== want.degen)
                        report_mismatch("degenerate", degenerate, want.degen);
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic send_pair(pair_t p);
        int gap_len;
        box_a_x <= p.ax; box_a_y <= p.ay; box_a_w <= p.aw; box_a_h <= p.ah;
        box_b_x <= p.bx; box_b_y <= p.by; box_b_w <= p.bw; box_b_h <= p.bh;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_scores.insert(expected_scores.size(), score_pair(p));
        @(negedge clk);
        gap_len = ($urandom_range(0, 9) < 6) ? 0 :
                  ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap_len > 0)
        begin
            start <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
    endtask

    function automatic logic [CB-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return CB'($urandom_range(0, 8));
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic pair_t pair_of(int ax, int ay, int aw, int ah,
                                      int bx, int by, int bw, int bh);
        pair_t p;
        p = {CB'(ax), CB'(ay), CB'(aw), CB'(ah), CB'(bx), CB'(by), CB'(bw), CB'(bh)};
        return p;
    endfunction

    task automatic test_directed();
        send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(pair_of(4095, 4095, 0, 0, 4095, 4095, 0, 0));
        send_pair(pair_of(5, 5, 0, 0, 9, 9, 0, 0));
        send_pair(pair_of(0, 0, 4095, 4095, 0, 0, 4095, 4095));
        send_pair(pair_of(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_pair(pair_of(0, 0, 1, 1, 4095, 4095, 4095, 4095));
        send_pair(pair_of(0, 0, 4095, 4095, 4095, 4095, 4095, 4095));
        send_pair(pair_of(10, 10, 20, 20, 15, 15, 20, 20));
        send_pair(pair_of(10, 10, 20, 20, 40, 10, 20, 20));
        send_pair(pair_of(0, 0, 100, 100, 25, 25, 50, 50));
        send_pair(pair_of(0, 0, 0, 50, 10, 0, 0, 50));
        send_pair(pair_of(0, 0, 50, 0, 0, 0, 50, 0));
        send_pair(pair_of(0, 0, 4095, 0, 0, 4095, 0, 4095));
        send_pair(pair_of(2730, 1365, 2730, 1365, 1365, 2730, 1365, 2730));
        send_pair(pair_of(0, 0, 1, 1, 1, 1, 1, 1));
    endtask

    task automatic test_random();
        pair_t p;
        repeat (1650)
        begin
            p = pair_of($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
            case ($urandom_range(0, 3))
                0:
                begin
                    // pair near one another with small sizes, which may or may not overlap
                    p.bx = p.ax + CB'($urandom_range(0, 64));
                    p.by = p.ay + CB'($urandom_range(0, 64));
                    p.aw = CB'($urandom_range(0, 200));
                    p.ah = CB'($urandom_range(0, 200));
                    p.bw = CB'($urandom_range(0, 200));
                    p.bh = CB'($urandom_range(0, 200));
                end
                1:
                begin
                    p = pair_of(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                                pick_coord(), pick_coord(), pick_coord(), pick_coord());
                end
                default: ;
            endcase
            send_pair(p);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {box_a_x, box_a_y, box_a_w, box_a_h} = '0;
        {box_b_x, box_b_y, box_b_w, box_b_h} = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        start <= 1'b0;
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

[filelist.f]
sv/bdiou_pkg.sv
sv/bdiou_div_cell.sv
sv/bdiou_geom.sv
sv/box_distance_iou_unit.sv
tb/sv/tb.sv
